/* hw/rtl/bra_pkg.sv */
// Shared types and constants of the banker's resource allocator.
// No dependencies; imported by the top level, the port checker and the testbench.
`timescale 1ns / 1ps

package bra_pkg;

    // Widths of the fields of one word on each channel.
    localparam int OPCODE_W = 3;
    localparam int PROC_W   = 3;
    localparam int RES_W    = 2;
    localparam int AMT_W    = 16;
    localparam int OUT_W    = 16;

    // Width and limit of the working free counts inside the safety check.
    localparam int            WORK_W   = 20;
    localparam logic [19:0]   WORK_MAX = 20'hFFFFF;

    // Operation codes. The two spare codes leave the state alone.
    localparam logic [2:0] OP_LOAD_FREE  = 3'd0;
    localparam logic [2:0] OP_LOAD_MAX   = 3'd1;
    localparam logic [2:0] OP_LOAD_ALLOC = 3'd2;
    localparam logic [2:0] OP_CHECK      = 3'd3;
    localparam logic [2:0] OP_RELEASE    = 3'd4;
    localparam logic [2:0] OP_REQUEST    = 3'd5;
    localparam logic [2:0] OP_SPARE0     = 3'd6;
    localparam logic [2:0] OP_SPARE1     = 3'd7;

    // Result status codes.
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_EXCEEDS = 2'd1;
    localparam logic [1:0] ST_NO_FREE = 2'd2;
    localparam logic [1:0] ST_UNSAFE  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_INIT,
        S_SCAN,
        S_ROLL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [PROC_W-1:0]   process;
        logic [RES_W-1:0]    resource;
        logic [AMT_W-1:0]    amount;
    } t_in;

    typedef struct packed {
        logic             granted;
        logic [1:0]       status;
        logic             safe;
        logic [OUT_W-1:0] free_after;
        logic [OUT_W-1:0] need_after;
    } t_out;

endpackage

/* hw/rtl/bankers_resource_allocator_top.sv */
// Banker's algorithm allocator: state tables, operation datapath and safety-check sequencer.
// Depends on bra_pkg for the word types, operation codes and status codes.
`timescale 1ns / 1ps

// How to use this block:
// The input channel (i_valid / o_ready / i_data) takes one operation word: an opcode,
// a process index, a resource index and an amount. The output channel
// (o_valid / i_ready / o_data) returns exactly one result word per operation.
// An operation word is taken only while the sequencer is idle. It passes through the
// operation datapath and a step that seeds the safety check, and then the check
// visits one process row per cycle, testing all resources of that row at once.
// Rows are swept in order until every process has finished or a whole sweep makes
// no progress. A request that turns out unsafe is rolled back in a separate state
// before its result is loaded. The row compare and add unit is shared by all rows.
// The next word is taken once the result is loaded, so the block does not take a
// new word before it is through with the last one.
// The result sits in an output register, so once it is loaded the block is idle
// again and takes the next word while the receiver still stalls. If the receiver
// has not taken the previous result when a new one is ready, the sequencer waits.
// Synchronous reset clears all tables (maximum demand, allocation, need, free
// units), the finished flags and the handshake state.

module bankers_resource_allocator_top #(
    parameter int NUM_PROCESSES = 8,
    parameter int NUM_RESOURCES = 4,
    parameter int UNIT_WIDTH    = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bra_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output bra_pkg::t_out o_data
);
    import bra_pkg::*;

    // Index widths of the tables, and widths wide enough to compare the fields
    // against the table sizes.
    localparam int PIW  = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
    localparam int RIW  = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int PCW  = $clog2(NUM_PROCESSES + 1);
    localparam int RCW  = $clog2(NUM_RESOURCES + 1);
    localparam int PXW  = (PCW > PROC_W) ? ((PCW > PIW) ? PCW : PIW)
                                         : ((PROC_W > PIW) ? PROC_W : PIW);
    localparam int RXW  = (RCW > RES_W) ? ((RCW > RIW) ? RCW : RIW)
                                        : ((RES_W > RIW) ? RES_W : RIW);
    localparam int AXW  = (UNIT_WIDTH > AMT_W) ? UNIT_WIDTH : AMT_W;
    // Compare width inside the safety check.
    localparam int CW   = (UNIT_WIDTH > WORK_W) ? UNIT_WIDTH : WORK_W;
    localparam int CNTW = $clog2(NUM_PROCESSES + 1);

    localparam logic [UNIT_WIDTH-1:0] UNIT_MAX  = {UNIT_WIDTH{1'b1}};
    localparam logic [CW-1:0]         WMAX_EXT  = CW'(WORK_MAX);
    localparam logic [PIW-1:0]        LAST_PROC = PIW'(NUM_PROCESSES - 1);
    localparam logic [CNTW-1:0]       ALL_PROCS = CNTW'(NUM_PROCESSES);

    function automatic logic [UNIT_WIDTH-1:0] sat_add(
        input logic [UNIT_WIDTH-1:0] a,
        input logic [UNIT_WIDTH-1:0] b
    );
        logic [UNIT_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[UNIT_WIDTH] ? UNIT_MAX : s[UNIT_WIDTH-1:0];
    endfunction

    function automatic logic [UNIT_WIDTH-1:0] sat_sub(
        input logic [UNIT_WIDTH-1:0] a,
        input logic [UNIT_WIDTH-1:0] b
    );
        return (a > b) ? (a - b) : '0;
    endfunction

    // State tables. Each table is read at the addressed cell; need and allocation also at the row under scan.
    logic [UNIT_WIDTH-1:0] r_max   [NUM_PROCESSES][NUM_RESOURCES];
    logic [UNIT_WIDTH-1:0] r_alloc [NUM_PROCESSES][NUM_RESOURCES];
    logic [UNIT_WIDTH-1:0] r_need  [NUM_PROCESSES][NUM_RESOURCES];
    logic [UNIT_WIDTH-1:0] r_free  [NUM_RESOURCES];

    // Safety check working state.
    logic [WORK_W-1:0]        r_work [NUM_RESOURCES];
    logic [WORK_W-1:0]        n_work [NUM_RESOURCES];
    logic [NUM_PROCESSES-1:0] r_fin, n_fin;
    logic [CNTW-1:0]          r_cnt, n_cnt;
    logic [PIW-1:0]           r_scan, n_scan;
    logic                     r_prog, n_prog;

    // Sequencer and the operation being worked on.
    t_state                r_state, n_state;
    logic [2:0]            r_op;
    logic [PIW-1:0]        r_pidx;
    logic [RIW-1:0]        r_ridx;
    logic                  r_pok, r_rok;
    logic [UNIT_WIDTH-1:0] r_amt;
    logic                  r_granted, n_granted;
    logic [1:0]            r_status, n_status;
    logic                  r_tent, n_tent;
    logic                  r_safe, n_safe;

    // Output register.
    logic r_ovalid, n_ovalid;
    t_out r_odata, n_odata;

    // Field decode at the input.
    logic [PXW-1:0] in_pext;
    logic [RXW-1:0] in_rext;
    logic [AXW-1:0] in_aext;
    logic           in_pok, in_rok;

    assign in_pext = PXW'(i_data.process);
    assign in_rext = RXW'(i_data.resource);
    assign in_aext = AXW'(i_data.amount);
    assign in_pok  = in_pext < PXW'(NUM_PROCESSES);
    assign in_rok  = in_rext < RXW'(NUM_RESOURCES);

    // Cell writes from the operation datapath.
    logic                  wr_free, wr_max, wr_alloc, wr_need;
    logic [UNIT_WIDTH-1:0] wd_free, wd_max, wd_alloc, wd_need;

    logic [UNIT_WIDTH-1:0] cur_free, cur_max, cur_alloc, cur_need, tmp_sum;

    assign cur_free  = r_free[r_ridx];
    assign cur_max   = r_max[r_pidx][r_ridx];
    assign cur_alloc = r_alloc[r_pidx][r_ridx];
    assign cur_need  = r_need[r_pidx][r_ridx];

    // Row test of the safety check.
    logic row_fits, chk_done, chk_safe;
    logic [CNTW-1:0] cnt_step;
    logic            prog_step;
    logic [CW:0]     work_sum [NUM_RESOURCES];

    always_comb begin
        row_fits = !r_fin[r_scan];
        for (int r = 0; r < NUM_RESOURCES; r++) begin
            if (CW'(r_need[r_scan][r]) > CW'(r_work[r])) begin
                row_fits = 1'b0;
            end
            work_sum[r] = (CW + 1)'(r_work[r]) + (CW + 1)'(r_alloc[r_scan][r]);
        end
        cnt_step  = r_cnt + CNTW'(row_fits);
        prog_step = r_prog | row_fits;
        chk_done  = (cnt_step == ALL_PROCS) || ((r_scan == LAST_PROC) && !prog_step);
        chk_safe  = (cnt_step == ALL_PROCS);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: n_state = S_INIT;
            S_INIT: n_state = S_SCAN;
            S_SCAN: begin
                if (chk_done) begin
                    n_state = (r_tent && !chk_safe) ? S_ROLL : S_DONE;
                end
            end
            S_ROLL: n_state = S_DONE;
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs of each state.
    always_comb begin
        wr_free   = 1'b0;
        wr_max    = 1'b0;
        wr_alloc  = 1'b0;
        wr_need   = 1'b0;
        wd_free   = cur_free;
        wd_max    = cur_max;
        wd_alloc  = cur_alloc;
        wd_need   = cur_need;
        tmp_sum   = '0;
        n_granted = r_granted;
        n_status  = r_status;
        n_tent    = r_tent;
        n_safe    = r_safe;
        n_work    = r_work;
        n_fin     = r_fin;
        n_cnt     = r_cnt;
        n_scan    = r_scan;
        n_prog    = r_prog;
        n_ovalid  = r_ovalid && !i_ready;
        n_odata   = r_odata;

        case (r_state)
            S_IDLE: begin
                n_granted = 1'b0;
                n_status  = ST_DONE;
                n_tent    = 1'b0;
                n_safe    = 1'b0;
            end
            S_EXEC: begin
                case (r_op)
                    OP_LOAD_FREE: begin
                        if (r_rok) begin
                            wr_free   = 1'b1;
                            wd_free   = r_amt;
                            n_granted = 1'b1;
                        end
                    end
                    OP_LOAD_MAX: begin
                        if (r_pok && r_rok) begin
                            wr_max    = 1'b1;
                            wd_max    = r_amt;
                            wr_need   = 1'b1;
                            wd_need   = sat_sub(r_amt, cur_alloc);
                            n_granted = 1'b1;
                        end
                    end
                    OP_LOAD_ALLOC: begin
                        if (r_pok && r_rok) begin
                            tmp_sum   = sat_add(cur_free, cur_alloc);
                            wr_free   = 1'b1;
                            wd_free   = sat_sub(tmp_sum, r_amt);
                            wr_alloc  = 1'b1;
                            wd_alloc  = r_amt;
                            wr_need   = 1'b1;
                            wd_need   = sat_sub(cur_max, r_amt);
                            n_granted = 1'b1;
                        end
                    end
                    OP_CHECK: n_granted = 1'b1;
                    OP_RELEASE: begin
                        if (r_pok && r_rok) begin
                            if (r_amt > cur_alloc) begin
                                n_status = ST_EXCEEDS;
                            end else begin
                                wr_alloc  = 1'b1;
                                wd_alloc  = cur_alloc - r_amt;
                                wr_free   = 1'b1;
                                wd_free   = sat_add(cur_free, r_amt);
                                wr_need   = 1'b1;
                                wd_need   = sat_add(cur_need, r_amt);
                                n_granted = 1'b1;
                            end
                        end
                    end
                    OP_REQUEST: begin
                        if (r_pok && r_rok) begin
                            if (r_amt > cur_need) begin
                                n_status = ST_EXCEEDS;
                            end else if (r_amt > cur_free) begin
                                n_status = ST_NO_FREE;
                            end else begin
                                // Applied tentatively; the check decides whether it stays.
                                wr_free  = 1'b1;
                                wd_free  = cur_free - r_amt;
                                wr_alloc = 1'b1;
                                wd_alloc = sat_add(cur_alloc, r_amt);
                                wr_need  = 1'b1;
                                wd_need  = cur_need - r_amt;
                                n_tent   = 1'b1;
                            end
                        end
                    end
                    default: n_status = ST_DONE;
                endcase
            end
            S_INIT: begin
                for (int r = 0; r < NUM_RESOURCES; r++) begin
                    n_work[r] = (CW'(r_free[r]) > WMAX_EXT) ? WORK_MAX
                                                            : WORK_W'(r_free[r]);
                end
                n_fin  = '0;
                n_cnt  = '0;
                n_scan = '0;
                n_prog = 1'b0;
            end
            S_SCAN: begin
                if (row_fits) begin
                    n_fin[r_scan] = 1'b1;
                    for (int r = 0; r < NUM_RESOURCES; r++) begin
                        n_work[r] = (work_sum[r] > (CW + 1)'(WMAX_EXT)) ? WORK_MAX
                                                                       : WORK_W'(work_sum[r]);
                    end
                end
                n_cnt  = cnt_step;
                n_prog = prog_step;
                if (r_scan == LAST_PROC) begin
                    n_scan = '0;
                    n_prog = 1'b0;
                end else begin
                    n_scan = r_scan + PIW'(1);
                end
                if (chk_done) begin
                    n_safe = chk_safe;
                    if (r_tent && chk_safe) begin
                        n_granted = 1'b1;
                    end
                end
            end
            S_ROLL: begin
                wr_free   = 1'b1;
                wd_free   = cur_free + r_amt;
                wr_alloc  = 1'b1;
                wd_alloc  = cur_alloc - r_amt;
                wr_need   = 1'b1;
                wd_need   = cur_need + r_amt;
                n_status  = ST_UNSAFE;
                n_granted = 1'b0;
                n_safe    = 1'b0;
            end
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid           = 1'b1;
                    n_odata.granted    = r_granted;
                    n_odata.status     = r_status;
                    n_odata.safe       = r_safe;
                    n_odata.free_after = r_rok ? OUT_W'(cur_free) : '0;
                    n_odata.need_after = (r_pok && r_rok) ? OUT_W'(cur_need) : '0;
                end
            end
            default: n_status = ST_DONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_tent   <= 1'b0;
            r_fin    <= '0;
            r_cnt    <= '0;
            r_scan   <= '0;
            r_prog   <= 1'b0;
            for (int p = 0; p < NUM_PROCESSES; p++) begin
                for (int r = 0; r < NUM_RESOURCES; r++) begin
                    r_max[p][r]   <= '0;
                    r_alloc[p][r] <= '0;
                    r_need[p][r]  <= '0;
                end
            end
            for (int r = 0; r < NUM_RESOURCES; r++) begin
                r_free[r] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_tent   <= n_tent;
            r_fin    <= n_fin;
            r_cnt    <= n_cnt;
            r_scan   <= n_scan;
            r_prog   <= n_prog;
            if (wr_free) begin
                r_free[r_ridx] <= wd_free;
            end
            if (wr_max) begin
                r_max[r_pidx][r_ridx] <= wd_max;
            end
            if (wr_alloc) begin
                r_alloc[r_pidx][r_ridx] <= wd_alloc;
            end
            if (wr_need) begin
                r_need[r_pidx][r_ridx] <= wd_need;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_granted <= n_granted;
        r_status  <= n_status;
        r_safe    <= n_safe;
        r_work    <= n_work;
        r_odata   <= n_odata;
        if (r_state == S_IDLE && i_valid) begin
            r_op   <= i_data.opcode;
            r_pok  <= in_pok;
            r_rok  <= in_rok;
            r_pidx <= in_pok ? in_pext[PIW-1:0] : '0;
            r_ridx <= in_rok ? in_rext[RIW-1:0] : '0;
            r_amt  <= in_aext[UNIT_WIDTH-1:0];
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

endmodule

/* hw/rtl/bra_checker.sv */
// Port-level checker of the banker's resource allocator, bound to its top level.
// Depends on bra_pkg for the word types and status codes.
`timescale 1ns / 1ps

module bra_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input bra_pkg::t_in  i_data,
    input logic          o_valid,
    input logic          i_ready,
    input bra_pkg::t_out o_data
);
    import bra_pkg::*;

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result word changed while stalled");

    // A granted operation always reports success.
    a_grant_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.granted && (o_data.status != ST_DONE)))
        else $error("granted word with a failure status");

    // A rolled-back request reports an unsafe state and no grant.
    a_unsafe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.status == ST_UNSAFE) |-> !o_data.safe && !o_data.granted)
        else $error("unsafe status with safe or granted set");

    // The block is not ready again right after it accepts a word.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready right after accepting a word");

endmodule

bind bankers_resource_allocator_top bra_checker u_bra_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

/* dv/bra_checker.sv */
// Watches both channels of the banker's allocator, predicts each result word, and compares.
// Depends on bra_pkg for the word types, operation codes and status codes.
`timescale 1ns / 1ps

module tb_bra_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_ready_in,
    input  bra_pkg::t_in  i_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  bra_pkg::t_out i_out_data,
    output int            o_fail_count,
    output int            o_pending
);
    import bra_pkg::*;

    localparam int NP = 8;
    localparam int NR = 4;

    logic [15:0] max_tab [NP][NR];
    logic [15:0] alloc_tab [NP][NR];
    logic [15:0] need_tab [NP][NR];
    logic [15:0] free_tab [NR];
    t_out        expected_q [$];

    function automatic logic [15:0] sub_floor(logic [16:0] a, logic [16:0] b);
        return (a > b) ? 16'(a - b) : 16'd0;
    endfunction

    function automatic logic [15:0] add_cap(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    // Banker's safety test: greedily finish the lowest process whose need fits.
    function automatic logic is_safe();
        logic [19:0] work [NR];
        logic        done [NP];
        logic        found;
        logic        fits;
        logic [20:0] s;
        int          pick;
        for (int r = 0; r < NR; r++) work[r] = {4'd0, free_tab[r]};
        for (int p = 0; p < NP; p++) done[p] = 1'b0;
        for (int pass = 0; pass < NP; pass++) begin
            found = 1'b0;
            pick = 0;
            for (int p = 0; p < NP; p++) begin
                if (!found && !done[p]) begin
                    fits = 1'b1;
                    for (int r = 0; r < NR; r++)
                        if ({4'd0, need_tab[p][r]} > work[r]) fits = 1'b0;
                    if (fits) begin
                        found = 1'b1;
                        pick = p;
                    end
                end
            end
            if (!found) return 1'b0;
            done[pick] = 1'b1;
            for (int r = 0; r < NR; r++) begin
                s = {1'b0, work[r]} + {5'd0, alloc_tab[pick][r]};
                work[r] = s[20] ? WORK_MAX : s[19:0];
            end
        end
        return 1'b1;
    endfunction

    function automatic t_out apply_operation(t_in w);
        t_out        res;
        logic        rolled;
        logic [15:0] f;
        int          p;
        int          r;
        p = w.process;
        r = w.resource;
        rolled = 1'b0;
        res = '0;
        case (w.opcode)
            OP_LOAD_FREE: begin
                free_tab[r] = w.amount;
                res.granted = 1'b1;
            end
            OP_LOAD_MAX: begin
                max_tab[p][r] = w.amount;
                need_tab[p][r] = sub_floor(max_tab[p][r], alloc_tab[p][r]);
                res.granted = 1'b1;
            end
            OP_LOAD_ALLOC: begin
                f = add_cap(free_tab[r], alloc_tab[p][r]);
                free_tab[r] = sub_floor(f, w.amount);
                alloc_tab[p][r] = w.amount;
                need_tab[p][r] = sub_floor(max_tab[p][r], alloc_tab[p][r]);
                res.granted = 1'b1;
            end
            OP_CHECK: res.granted = 1'b1;
            OP_RELEASE: begin
                if (w.amount > alloc_tab[p][r]) begin
                    res.status = ST_EXCEEDS;
                end else begin
                    alloc_tab[p][r] -= w.amount;
                    free_tab[r] = add_cap(free_tab[r], w.amount);
                    need_tab[p][r] = add_cap(need_tab[p][r], w.amount);
                    res.granted = 1'b1;
                end
            end
            OP_REQUEST: begin
                if (w.amount > need_tab[p][r]) begin
                    res.status = ST_EXCEEDS;
                end else if (w.amount > free_tab[r]) begin
                    res.status = ST_NO_FREE;
                end else begin
                    free_tab[r] -= w.amount;
                    alloc_tab[p][r] = add_cap(alloc_tab[p][r], w.amount);
                    need_tab[p][r] -= w.amount;
                    if (!is_safe()) begin
                        free_tab[r] += w.amount;
                        alloc_tab[p][r] -= w.amount;
                        need_tab[p][r] += w.amount;
                        res.status = ST_UNSAFE;
                        rolled = 1'b1;
                    end else begin
                        res.granted = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.safe = rolled ? 1'b0 : is_safe();
        res.free_after = free_tab[r];
        res.need_after = need_tab[p][r];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out exp_word;
        if (!i_rst_n) begin
            for (int p = 0; p < NP; p++)
                for (int r = 0; r < NR; r++) begin
                    max_tab[p][r] = '0;
                    alloc_tab[p][r] = '0;
                    need_tab[p][r] = '0;
                end
            for (int r = 0; r < NR; r++) free_tab[r] = '0;
            expected_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_valid && i_ready_in) expected_q.push_back(apply_operation(i_data));
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, i_out_data);
                    o_fail_count++;
                end else begin
                    exp_word = expected_q.pop_front();
                    if (i_out_data.granted !== exp_word.granted
                        || i_out_data.status !== exp_word.status
                        || i_out_data.safe !== exp_word.safe
                        || i_out_data.free_after !== exp_word.free_after
                        || i_out_data.need_after !== exp_word.need_after) begin
                        $display("%0t: mismatch, expected g%b s%0d safe%b free%0d need%0d,",
                                 $time, exp_word.granted, exp_word.status, exp_word.safe,
                                 exp_word.free_after, exp_word.need_after);
                        $display("%0t:           actual   g%b s%0d safe%b free%0d need%0d",
                                 $time, i_out_data.granted, i_out_data.status,
                                 i_out_data.safe, i_out_data.free_after,
                                 i_out_data.need_after);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

/* dv/tb_bankers_resource_allocator_top.sv */
// Stimulus and verdict for the banker's allocator; the checker predicts and compares.
// Depends on bra_pkg, tb_bra_checker and bankers_resource_allocator_top.
`timescale 1ns / 1ps

module tb_bankers_resource_allocator_top;
    import bra_pkg::*;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_ready;
    t_in   in_word;
    logic  out_valid;
    logic  out_ready;
    t_out  out_word;
    int    fail_count;
    int    pending;

    // Control between the stimulus process and the receiver process.
    logic  rx_hold;
    logic  rx_quiet;

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    bankers_resource_allocator_top uut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_valid(in_valid),
        .o_ready(in_ready),
        .i_data (in_word),
        .o_valid(out_valid),
        .i_ready(out_ready),
        .o_data (out_word)
    );

    tb_bra_checker checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .i_ready_in  (in_ready),
        .i_data      (in_word),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_word),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Send one word: drive it at a falling edge and hold it until the block takes it.
    // The valid is lowered only after acceptance, so back-to-back words keep it high.
    task automatic send_word(logic [2:0] op, int p, int r, logic [15:0] amt);
        in_valid <= 1'b1;
        in_word  <= '{opcode: op, process: 3'(p), resource: 2'(r), amount: amt};
        do @(posedge clk); while (!(in_valid && in_ready));
        @(negedge clk);
    endtask

    // Sender gap: a random burst of idle cycles, now and then.
    task automatic maybe_gap();
        int n;
        if (!rx_quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            n = $urandom_range(1, 17);
            repeat (n) @(negedge clk);
        end
    endtask

    // A random amount, biased toward small values so requests often fit, with
    // full-width and extreme values mixed in.
    function automatic logic [15:0] rand_amount();
        case ($urandom_range(0, 9))
            0: return 16'hFFFF;
            1: return 16'(~$urandom_range(0, 3));
            2: return 16'($urandom());
            3: return 16'd0;
            default: return 16'($urandom_range(0, 40));
        endcase
    endfunction

    // Receiver: random stall bursts unless quiet, or held off entirely.
    initial begin
        int n;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_hold) begin
                out_ready <= 1'b0;
            end else if (!rx_quiet && $urandom_range(0, 4) == 0) begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 17);
                repeat (n - 1) @(negedge clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Stimulus.
    initial begin
        int pick;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_word  = '0;
        rx_hold  = 1'b0;
        rx_quiet = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed part: a classic safe scenario, then the special cases.
        send_word(OP_CHECK, 0, 0, 16'd0);
        for (int r = 0; r < 4; r++) send_word(OP_LOAD_FREE, 0, r, 16'd10);
        send_word(OP_LOAD_MAX, 0, 0, 16'd7);
        send_word(OP_LOAD_MAX, 1, 1, 16'hFFFF);
        send_word(OP_LOAD_ALLOC, 0, 0, 16'd3);
        send_word(OP_LOAD_ALLOC, 7, 3, 16'hFFFF);   // takes more than is free
        send_word(OP_LOAD_ALLOC, 7, 3, 16'd0);      // gives it back
        send_word(OP_REQUEST, 0, 0, 16'd5);         // beyond need
        send_word(OP_REQUEST, 1, 1, 16'd20);        // beyond free units
        send_word(OP_REQUEST, 1, 1, 16'd9);         // leaves the state unsafe
        send_word(OP_REQUEST, 0, 0, 16'd4);         // also rolled back as unsafe
        send_word(OP_RELEASE, 0, 0, 16'd8);         // beyond allocation
        send_word(OP_RELEASE, 0, 0, 16'd7);
        send_word(OP_RELEASE, 0, 0, 16'd0);
        send_word(OP_SPARE0, 2, 2, 16'd1);          // unused opcodes
        send_word(OP_SPARE1, 5, 1, 16'hFFFF);
        send_word(OP_LOAD_FREE, 7, 3, 16'hFFFF);
        send_word(OP_RELEASE, 7, 3, 16'd0);
        send_word(OP_CHECK, 7, 3, 16'hFFFF);

        // Long receiver hold-off: the output register fills and the input stalls.
        rx_hold = 1'b1;
        fork
            begin
                repeat (300) @(negedge clk);
                rx_hold = 1'b0;
            end
            for (int i = 0; i < 6; i++) send_word(OP_CHECK, i, i % 4, 16'(i));
        join
        in_valid <= 1'b0;

        // Random part, mostly well-formed: loads of small values and requests
        // that fit, plus releases and noise.
        for (int i = 0; i < 830; i++) begin
            if (i == 400) begin
                // Sender pause until every expected word has come back.
                in_valid <= 1'b0;
                while (pending != 0) @(negedge clk);
            end
            if (i == 700) rx_quiet = 1'b1;
            pick = $urandom_range(0, 19);
            if (pick < 2)
                send_word(OP_LOAD_FREE, $urandom_range(0, 7), $urandom_range(0, 3),
                          (pick == 0) ? rand_amount() : 16'($urandom_range(10, 60)));
            else if (pick < 5)
                send_word(OP_LOAD_MAX, $urandom_range(0, 7), $urandom_range(0, 3),
                          16'($urandom_range(0, 30)));
            else if (pick < 7)
                send_word(OP_LOAD_ALLOC, $urandom_range(0, 7), $urandom_range(0, 3),
                          16'($urandom_range(0, 12)));
            else if (pick < 8)
                send_word(OP_CHECK, $urandom_range(0, 7), $urandom_range(0, 3),
                          rand_amount());
            else if (pick < 11)
                send_word(OP_RELEASE, $urandom_range(0, 7), $urandom_range(0, 3),
                          (pick == 8) ? rand_amount() : 16'($urandom_range(0, 6)));
            else if (pick < 19)
                send_word(OP_REQUEST, $urandom_range(0, 7), $urandom_range(0, 3),
                          (pick == 11) ? rand_amount() : 16'($urandom_range(0, 8)));
            else
                send_word(($urandom_range(0, 1) == 0) ? OP_SPARE0 : OP_SPARE1,
                          $urandom_range(0, 7), $urandom_range(0, 3), rand_amount());
            maybe_gap();
        end
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (80) @(negedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/bra_pkg.sv
hw/rtl/bankers_resource_allocator_top.sv
hw/rtl/bra_checker.sv
dv/bra_checker.sv
dv/tb_bankers_resource_allocator_top.sv
